### src/obbov_pkg.sv
// ----------------------------------------------------------------------------
// obbov_pkg
// Shared widths, types and helpers for the oriented box / cell overlap test.
// ----------------------------------------------------------------------------
package obbov_pkg;

	localparam int CB   = 21;          // bits per packed vector component
	localparam int FW   = 63;          // packed vector field width
	localparam int AF   = CB - 2;      // fraction bits of an axis component
	localparam int LW   = CB + 1;      // axis / offset component width, signed
	localparam int PW   = 2 * LW;      // component product width
	localparam int DW   = PW + 2;      // three-term dot product width
	localparam int MW   = 2 * CB + 1;  // dot product magnitude width
	localparam int LOB  = CB + 1;      // low slice of a magnitude for splitting
	localparam int HIB  = MW - LOB;    // high slice
	localparam int TW   = CB + MW;     // one radius term
	localparam int CW   = 2 * CB + 2;  // cell radius sum before scaling
	localparam int RW   = TW + 3;      // full radius sum
	localparam int NAX  = 15;          // candidate axes
	localparam int DEPTH = 7;          // pipeline stages

	typedef struct packed {
		logic signed [LW-1:0] x;
		logic signed [LW-1:0] y;
		logic signed [LW-1:0] z;
	} lvec_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stg_en_t;

	function automatic logic signed [CB-1:0] comp_get(input logic [FW-1:0] f,
		input logic [1:0] idx);
		return f[idx*CB +: CB];
	endfunction

	function automatic logic [CB-1:0] comp_mag(input logic signed [CB-1:0] c);
		return c[CB-1] ? -c : c;
	endfunction

	function automatic lvec_t vec_get(input logic [FW-1:0] f);
		lvec_t v;
		v.x = LW'(comp_get(f, 2'd0));
		v.y = LW'(comp_get(f, 2'd1));
		v.z = LW'(comp_get(f, 2'd2));
		return v;
	endfunction

endpackage

### src/obbov_pair_if.sv
// ----------------------------------------------------------------------------
// obbov_pair_if
// Input channel: one oriented box and one cell per word.
// ----------------------------------------------------------------------------
interface obbov_pair_if;
	logic                    valid;
	logic                    ready;
	logic [obbov_pkg::FW-1:0] obb_center;
	logic [obbov_pkg::FW-1:0] obb_half;
	logic [obbov_pkg::FW-1:0] obb_axis_right;
	logic [obbov_pkg::FW-1:0] obb_axis_up;
	logic [obbov_pkg::FW-1:0] obb_axis_forward;
	logic [obbov_pkg::FW-1:0] cell_center;
	logic [obbov_pkg::FW-1:0] cell_half;

	modport source(output valid, obb_center, obb_half, obb_axis_right, obb_axis_up,
		obb_axis_forward, cell_center, cell_half, input ready);
	modport sink(input valid, obb_center, obb_half, obb_axis_right, obb_axis_up,
		obb_axis_forward, cell_center, cell_half, output ready);
endinterface

### src/obbov_result_if.sv
// ----------------------------------------------------------------------------
// obbov_result_if
// Output channel: one overlap flag per word.
// ----------------------------------------------------------------------------
interface obbov_result_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source(output valid, overlap, input ready);
	modport sink(input valid, overlap, output ready);
endinterface

### src/obbov_axis.sv
// ----------------------------------------------------------------------------
// obbov_axis
// Pipelined separation test along one candidate axis (stages 2 to 6).
// ----------------------------------------------------------------------------
module obbov_axis (
	input  logic                   clk,
	input  obbov_pkg::stg_en_t     en,
	input  obbov_pkg::lvec_t       axis_l,
	input  obbov_pkg::lvec_t       d,
	input  obbov_pkg::lvec_t       box [3],
	input  logic [obbov_pkg::CB-1:0] chm [3],
	input  logic [obbov_pkg::CB-1:0] hm [3],
	output logic                   sep
);
	localparam int CB  = obbov_pkg::CB;
	localparam int LW  = obbov_pkg::LW;
	localparam int PW  = obbov_pkg::PW;
	localparam int DW  = obbov_pkg::DW;
	localparam int MW  = obbov_pkg::MW;
	localparam int LOB = obbov_pkg::LOB;
	localparam int HIB = obbov_pkg::HIB;
	localparam int TW  = obbov_pkg::TW;
	localparam int CW  = obbov_pkg::CW;
	localparam int RW  = obbov_pkg::RW;
	localparam int AF  = obbov_pkg::AF;

	function automatic logic [CB-1:0] lmag(input logic signed [LW-1:0] v);
		logic signed [LW-1:0] n;
		n = v[LW-1] ? -v : v;
		return n[CB-1:0];
	endfunction

	function automatic logic [MW-1:0] dmag(input logic signed [PW-1:0] p0,
		input logic signed [PW-1:0] p1, input logic signed [PW-1:0] p2);
		logic signed [DW-1:0] s;
		logic signed [DW-1:0] m;
		s = DW'(p0) + DW'(p1) + DW'(p2);
		m = s[DW-1] ? -s : s;
		return m[MW-1:0];
	endfunction

	logic signed [PW-1:0] pd_s2 [3];
	logic signed [PW-1:0] pa_s2 [3][3];
	logic [2*CB-1:0]      pc_s2 [3];
	logic [MW-1:0]        dm_s3;
	logic [MW-1:0]        am_s3 [3];
	logic [CW-1:0]        cs_s3;
	logic [CB+LOB-1:0]    plo_s4 [3];
	logic [CB+HIB-1:0]    phi_s4 [3];
	logic [MW-1:0]        dm_s4;
	logic [CW-1:0]        cs_s4;
	logic [TW-1:0]        t_s5 [3];
	logic [MW-1:0]        dm_s5;
	logic [CW-1:0]        cs_s5;
	logic                 sep_s6;
	logic [RW-1:0]        rsum;
	logic [RW-1:0]        lhs;

	// component products of offset, box axes and cell half sizes with this axis
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pd_s2[0] <= d.x * axis_l.x;
			pd_s2[1] <= d.y * axis_l.y;
			pd_s2[2] <= d.z * axis_l.z;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k][0] <= box[k].x * axis_l.x;
				pa_s2[k][1] <= box[k].y * axis_l.y;
				pa_s2[k][2] <= box[k].z * axis_l.z;
			end
			pc_s2[0] <= chm[0] * lmag(axis_l.x);
			pc_s2[1] <= chm[1] * lmag(axis_l.y);
			pc_s2[2] <= chm[2] * lmag(axis_l.z);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dm_s3 <= dmag(pd_s2[0], pd_s2[1], pd_s2[2]);
			for (int k = 0; k < 3; k++) begin
				am_s3[k] <= dmag(pa_s2[k][0], pa_s2[k][1], pa_s2[k][2]);
			end
			cs_s3 <= CW'(pc_s2[0]) + CW'(pc_s2[1]) + CW'(pc_s2[2]);
		end
	end

	// split each half-extent product into two narrower multiplies
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < 3; k++) begin
				plo_s4[k] <= hm[k] * am_s3[k][LOB-1:0];
				phi_s4[k] <= hm[k] * am_s3[k][MW-1:LOB];
			end
			dm_s4 <= dm_s3;
			cs_s4 <= cs_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int k = 0; k < 3; k++) begin
				t_s5[k] <= (TW'(phi_s4[k]) << LOB) + TW'(plo_s4[k]);
			end
			dm_s5 <= dm_s4;
			cs_s5 <= cs_s4;
		end
	end

	always_comb begin
		rsum = RW'(t_s5[0]) + RW'(t_s5[1]) + RW'(t_s5[2]) + (RW'(cs_s5) << AF);
		lhs  = RW'(dm_s5) << AF;
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			sep_s6 <= lhs > rsum;
		end
	end

	assign sep = sep_s6;
endmodule

### src/obb_aabb_overlap_test_top.sv
// ----------------------------------------------------------------------------
// obb_aabb_overlap_test_top
// Separating-axis overlap test of an oriented box against an axis-aligned cell.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : valid/ready input; each word carries the box centre, scaled half
//            extents, three box axes, and the cell centre and half sizes.
//   result : valid/ready output; one word per pair, overlap = 1 when none of
//            the fifteen candidate axes (three box axes, three world axes,
//            nine cross products) separates the boxes. Touching counts as
//            overlap.
//   Throughput is one pair per cycle while result is not stalled; it is set
//   by the seven-stage pipeline, with all fifteen axes evaluated side by side
//   in their own axis units.
//   Each stage holds its word while the next stage is full and stalled, so a
//   stall on result backs up stage by stage; empty stages still fill, and a
//   full pipeline holds up to seven words with pair.ready low.
//   Reset clears all stage valid bits; the block accepts a word as soon as
//   reset is released.
// ----------------------------------------------------------------------------
module obb_aabb_overlap_test_top (
	input  logic              clk,
	input  logic              arst_n,
	obbov_pair_if.sink        pair,
	obbov_result_if.source    result
);
	localparam int CB  = obbov_pkg::CB;
	localparam int LW  = obbov_pkg::LW;
	localparam int AF  = obbov_pkg::AF;
	localparam int NAX = obbov_pkg::NAX;
	localparam logic signed [LW-1:0] AXIS_ONE = LW'(1 << AF);

	logic [7:1]              v_q;
	logic [7:1]              en;
	obbov_pkg::stg_en_t      stg_en;
	obbov_pkg::lvec_t        d_s1;
	obbov_pkg::lvec_t        ax_s1 [3];
	logic [CB-1:0]           hm_s1 [3];
	logic [CB-1:0]           chm_s1 [3];
	logic [CB-1:0]           hm_s2 [3];
	logic [CB-1:0]           hm_s3 [3];
	obbov_pkg::lvec_t        axl [NAX];
	logic [NAX-1:0]          sep;
	logic                    overlap_s7;

	// a stage advances when it is empty or the next one advances
	always_comb begin
		en[7] = !v_q[7] || result.ready;
		for (int s = 6; s >= 1; s--) begin
			en[s] = !v_q[s] || en[s+1];
		end
		stg_en.s2 = en[2];
		stg_en.s3 = en[3];
		stg_en.s4 = en[4];
		stg_en.s5 = en[5];
		stg_en.s6 = en[6];
	end

	assign pair.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= pair.valid;
			for (int s = 2; s <= 7; s++) begin
				if (en[s]) v_q[s] <= v_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			obbov_pkg::lvec_t bc;
			obbov_pkg::lvec_t cc;
			bc = obbov_pkg::vec_get(pair.obb_center);
			cc = obbov_pkg::vec_get(pair.cell_center);
			d_s1.x <= cc.x - bc.x;
			d_s1.y <= cc.y - bc.y;
			d_s1.z <= cc.z - bc.z;
			ax_s1[0] <= obbov_pkg::vec_get(pair.obb_axis_right);
			ax_s1[1] <= obbov_pkg::vec_get(pair.obb_axis_up);
			ax_s1[2] <= obbov_pkg::vec_get(pair.obb_axis_forward);
			for (int j = 0; j < 3; j++) begin
				hm_s1[j]  <= obbov_pkg::comp_mag(obbov_pkg::comp_get(pair.obb_half, 2'(j)));
				chm_s1[j] <= obbov_pkg::comp_mag(obbov_pkg::comp_get(pair.cell_half, 2'(j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) hm_s2 <= hm_s1;
		if (en[3]) hm_s3 <= hm_s2;
	end

	// candidate axes: box axes, world axes, box axis crossed with world axes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			axl[i] = ax_s1[i];
			axl[6+i*3]   = '{x: '0,            y: ax_s1[i].z,  z: -ax_s1[i].y};
			axl[6+i*3+1] = '{x: -ax_s1[i].z,   y: '0,          z: ax_s1[i].x};
			axl[6+i*3+2] = '{x: -ax_s1[i].y,   y: ax_s1[i].x,  z: '0};
		end
		axl[3] = '{x: AXIS_ONE, y: '0, z: '0};
		axl[4] = '{x: '0, y: AXIS_ONE, z: '0};
		axl[5] = '{x: '0, y: '0, z: -AXIS_ONE};
	end

	for (genvar a = 0; a < NAX; a++) begin : g_axis
		obbov_axis u_axis (
			.clk    (clk),
			.en     (stg_en),
			.axis_l (axl[a]),
			.d      (d_s1),
			.box    (ax_s1),
			.chm    (chm_s1),
			.hm     (hm_s3),
			.sep    (sep[a])
		);
	end

	always_ff @(posedge clk) begin
		if (en[7]) overlap_s7 <= ~|sep;
	end

	assign result.valid   = v_q[7];
	assign result.overlap = overlap_s7;
endmodule

### src/obbov_chk.sv
// ----------------------------------------------------------------------------
// obbov_chk
// Port-level checks on word flow through the overlap test pipeline.
// ----------------------------------------------------------------------------
module obbov_chk (
	input logic clk,
	input logic arst_n,
	input logic pair_valid,
	input logic pair_ready,
	input logic result_valid,
	input logic result_ready,
	input logic result_overlap
);
	localparam int DEPTH = obbov_pkg::DEPTH;

	logic [3:0] cnt_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = pair_valid && pair_ready;
	assign out_acc = result_valid && result_ready;

	// words inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_overlap))
		else $error("result word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != 4'd0)
		else $error("result word without a pending pair");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 4'd0 |-> pair_ready)
		else $error("empty block refuses a pair");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(DEPTH))
		else $error("more words in flight than stages");
endmodule

bind obb_aabb_overlap_test_top obbov_chk u_obbov_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.pair_valid     (pair.valid),
	.pair_ready     (pair.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_overlap (result.overlap)
);
